>>> design/ilt_pkg.sv
package ilt_pkg;

  localparam int unsigned WORD_W   = 32;
  localparam int unsigned REQ_W    = 4;
  localparam int unsigned POS_W    = 7;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned FPOS_W   = 6;
  localparam int unsigned LEN_W    = 7;

  typedef enum logic [REQ_W-1:0] {
    REQ_APPEND    = 4'd0,
    REQ_INSERT    = 4'd1,
    REQ_OVERWRITE = 4'd2,
    REQ_GET       = 4'd3,
    REQ_REMOVE    = 4'd4,
    REQ_POP       = 4'd5,
    REQ_SEARCH    = 4'd6,
    REQ_CONTAINS  = 4'd7,
    REQ_CLEAR     = 4'd8
  } req_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_BAD_POS   = 3'd1,
    ST_NULL      = 3'd2,
    ST_FULL      = 3'd3,
    ST_NOT_FOUND = 3'd4,
    ST_EMPTY     = 3'd5
  } status_e;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [WORD_W-1:0]   read_value;
    logic                found;
    logic [FPOS_W-1:0]   found_position;
    logic [LEN_W-1:0]    list_length;
  } res_t;

endpackage

>>> design/ilt_store.sv
module ilt_store #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic                      clk_i,
  input  logic                      we_i,
  input  logic [AW-1:0]             waddr_i,
  input  logic [ilt_pkg::WORD_W-1:0] wdata_i,
  input  logic                      re_i,
  input  logic [AW-1:0]             raddr_i,
  output logic [ilt_pkg::WORD_W-1:0] rdata_o
);

  logic [ilt_pkg::WORD_W-1:0] mem [DEPTH];
  logic [ilt_pkg::WORD_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/ilt_seq.sv
module ilt_seq #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = $clog2(DEPTH),
  parameter int unsigned LW    = $clog2(DEPTH + 1)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [ilt_pkg::REQ_W-1:0]    req_i,
  input  logic [ilt_pkg::POS_W-1:0]    pos_i,
  input  logic [ilt_pkg::WORD_W-1:0]   val_i,
  output logic                         res_valid_o,
  input  logic                         res_ready_i,
  output ilt_pkg::res_t                res_o,
  output logic                         we_o,
  output logic [AW-1:0]                waddr_o,
  output logic [ilt_pkg::WORD_W-1:0]   wdata_o,
  output logic                         re_o,
  output logic [AW-1:0]                raddr_o,
  input  logic [ilt_pkg::WORD_W-1:0]   rdata_i
);

  localparam int unsigned PW = (LW > ilt_pkg::POS_W) ? LW : ilt_pkg::POS_W;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_GET  = 7'b0000010,
    S_UP   = 7'b0000100,
    S_INS  = 7'b0001000,
    S_DOWN = 7'b0010000,
    S_SRCH = 7'b0100000,
    S_DONE = 7'b1000000
  } state_e;

  state_e                        state_q, state_d;
  logic [LW-1:0]                 len_q, len_d;
  logic [LW-1:0]                 idx_q, idx_d;
  logic [LW-1:0]                 pos_q, pos_d;
  logic [ilt_pkg::WORD_W-1:0]    val_q, val_d;
  logic [ilt_pkg::REQ_W-1:0]     op_q, op_d;
  logic [ilt_pkg::STATUS_W-1:0]  status_q, status_d;
  logic [ilt_pkg::WORD_W-1:0]    readv_q, readv_d;
  logic                          found_q, found_d;
  logic [ilt_pkg::FPOS_W-1:0]    fpos_q, fpos_d;

  logic                          val_null;
  logic                          full;
  logic [PW-1:0]                 pos_w;
  logic [PW-1:0]                 len_w;
  logic [LW-1:0]                 pos_in;
  logic [LW-1:0]                 pos_in_nx;
  logic [LW-1:0]                 pos_q_nx;
  logic [LW-1:0]                 len_m1;
  logic [LW-1:0]                 idx_m1;
  logic [LW-1:0]                 idx_m2;
  logic [LW-1:0]                 idx_p1;
  logic [LW:0]                   idx_p2;

  assign val_null  = (val_i == '0);
  assign full      = (len_q == LW'(DEPTH));
  assign pos_w     = PW'(pos_i);
  assign len_w     = PW'(len_q);
  assign pos_in    = LW'(pos_i);
  assign pos_in_nx = pos_in + LW'(1);
  assign pos_q_nx  = pos_q + LW'(1);
  assign len_m1    = len_q - LW'(1);
  assign idx_m1    = idx_q - LW'(1);
  assign idx_m2    = idx_q - LW'(2);
  assign idx_p1    = idx_q + LW'(1);
  assign idx_p2    = {1'b0, idx_q} + (LW+1)'(2);

  always_comb begin
    state_d  = state_q;
    len_d    = len_q;
    idx_d    = idx_q;
    pos_d    = pos_q;
    val_d    = val_q;
    op_d     = op_q;
    status_d = status_q;
    readv_d  = readv_q;
    found_d  = found_q;
    fpos_d   = fpos_q;
    we_o     = 1'b0;
    waddr_o  = idx_q[AW-1:0];
    wdata_o  = rdata_i;
    re_o     = 1'b0;
    raddr_o  = '0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          pos_d    = pos_in;
          val_d    = val_i;
          op_d     = req_i;
          status_d = ilt_pkg::ST_OK;
          readv_d  = '0;
          found_d  = 1'b0;
          fpos_d   = '0;
          state_d  = S_DONE;
          unique case (req_i)
            ilt_pkg::REQ_APPEND: begin
              if (val_null) begin
                status_d = ilt_pkg::ST_NULL;
              end else if (full) begin
                status_d = ilt_pkg::ST_FULL;
              end else begin
                we_o    = 1'b1;
                waddr_o = len_q[AW-1:0];
                wdata_o = val_i;
                len_d   = len_q + LW'(1);
              end
            end
            ilt_pkg::REQ_INSERT: begin
              if (val_null) begin
                status_d = ilt_pkg::ST_NULL;
              end else if (pos_w > len_w) begin
                status_d = ilt_pkg::ST_BAD_POS;
              end else if (full) begin
                status_d = ilt_pkg::ST_FULL;
              end else if (pos_w == len_w) begin
                we_o    = 1'b1;
                waddr_o = AW'(pos_i);
                wdata_o = val_i;
                len_d   = len_q + LW'(1);
              end else begin
                // Shift from the top down; the new word lands at the requested position.
                re_o    = 1'b1;
                raddr_o = len_m1[AW-1:0];
                idx_d   = len_q;
                state_d = S_UP;
              end
            end
            ilt_pkg::REQ_OVERWRITE: begin
              if (val_null) begin
                status_d = ilt_pkg::ST_NULL;
              end else if (pos_w >= len_w) begin
                status_d = ilt_pkg::ST_BAD_POS;
              end else begin
                we_o    = 1'b1;
                waddr_o = AW'(pos_i);
                wdata_o = val_i;
              end
            end
            ilt_pkg::REQ_GET, ilt_pkg::REQ_POP: begin
              if (pos_w >= len_w) begin
                status_d = ilt_pkg::ST_BAD_POS;
              end else begin
                re_o    = 1'b1;
                raddr_o = AW'(pos_i);
                state_d = S_GET;
              end
            end
            ilt_pkg::REQ_REMOVE: begin
              if (pos_w >= len_w) begin
                status_d = ilt_pkg::ST_BAD_POS;
              end else if (pos_in_nx < len_q) begin
                re_o    = 1'b1;
                raddr_o = pos_in_nx[AW-1:0];
                idx_d   = pos_in;
                state_d = S_DOWN;
              end else begin
                len_d = len_m1;
              end
            end
            ilt_pkg::REQ_SEARCH, ilt_pkg::REQ_CONTAINS: begin
              if (val_null) begin
                status_d = ilt_pkg::ST_NULL;
              end else if (len_q == '0) begin
                status_d = ilt_pkg::ST_NOT_FOUND;
              end else begin
                re_o    = 1'b1;
                raddr_o = '0;
                idx_d   = '0;
                state_d = S_SRCH;
              end
            end
            ilt_pkg::REQ_CLEAR: begin
              if (len_q == '0) begin
                status_d = ilt_pkg::ST_EMPTY;
              end else begin
                len_d = '0;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_GET: begin
        readv_d = rdata_i;
        state_d = S_DONE;
        if (op_q == ilt_pkg::REQ_POP) begin
          if (pos_q_nx < len_q) begin
            re_o    = 1'b1;
            raddr_o = pos_q_nx[AW-1:0];
            idx_d   = pos_q;
            state_d = S_DOWN;
          end else begin
            len_d = len_m1;
          end
        end
      end
      S_UP: begin
        // The read data is the word just below idx; the next read runs ahead.
        we_o    = 1'b1;
        waddr_o = idx_q[AW-1:0];
        wdata_o = rdata_i;
        if (idx_m1 > pos_q) begin
          re_o    = 1'b1;
          raddr_o = idx_m2[AW-1:0];
          idx_d   = idx_m1;
        end else begin
          state_d = S_INS;
        end
      end
      S_INS: begin
        we_o    = 1'b1;
        waddr_o = pos_q[AW-1:0];
        wdata_o = val_q;
        len_d   = len_q + LW'(1);
        state_d = S_DONE;
      end
      S_DOWN: begin
        we_o    = 1'b1;
        waddr_o = idx_q[AW-1:0];
        wdata_o = rdata_i;
        if (idx_p2 < {1'b0, len_q}) begin
          re_o    = 1'b1;
          raddr_o = idx_p2[AW-1:0];
          idx_d   = idx_p1;
        end else begin
          len_d   = len_m1;
          state_d = S_DONE;
        end
      end
      S_SRCH: begin
        if (rdata_i == val_q) begin
          found_d  = 1'b1;
          fpos_d   = ilt_pkg::FPOS_W'(idx_q);
          status_d = ilt_pkg::ST_OK;
          state_d  = S_DONE;
        end else if (idx_p1 < len_q) begin
          re_o    = 1'b1;
          raddr_o = idx_p1[AW-1:0];
          idx_d   = idx_p1;
        end else begin
          status_d = ilt_pkg::ST_NOT_FOUND;
          state_d  = S_DONE;
        end
      end
      S_DONE: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      len_q   <= '0;
    end else begin
      state_q <= state_d;
      len_q   <= len_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q    <= idx_d;
    pos_q    <= pos_d;
    val_q    <= val_d;
    op_q     <= op_d;
    status_q <= status_d;
    readv_q  <= readv_d;
    found_q  <= found_d;
    fpos_q   <= fpos_d;
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign res_valid_o = (state_q == S_DONE);

  assign res_o.status         = status_q;
  assign res_o.read_value     = readv_q;
  assign res_o.found          = found_q;
  assign res_o.found_position = fpos_q;
  assign res_o.list_length    = ilt_pkg::LEN_W'(len_q);

`ifndef SYNTHESIS
  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= LW'(DEPTH))
    else $error("list length beyond depth");

  a_up_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_UP) |-> (idx_q > pos_q) && (idx_q <= len_q))
    else $error("shift-up index out of range");

  a_found_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && found_q) |-> (status_q == ilt_pkg::ST_OK))
    else $error("match reported with a failing status");

  a_len_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (len_q != $past(len_q)) |->
      (len_q == $past(len_q) + LW'(1)) || (len_q == $past(len_q) - LW'(1)) ||
      (len_q == '0))
    else $error("list length moved by more than one entry");

  a_done_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && !res_ready_i) |=> (state_q == S_DONE))
    else $error("result dropped before the output register took it");
`endif

endmodule

>>> design/indexed_list_table.sv
// Channel  Direction  Handshake                 Fields
// in       input      in_valid_i / in_stall_o   req_type_i, position_in_i, element_value_i
// out      output     out_valid_o / out_stall_i status_o, read_value_o, found_o,
//                                               found_position_o, list_length_out_o
//
// Append, overwrite, clear and rejected requests pass from idle straight to the done
// state, get through a store read first; insert, remove, pop and search walk the store
// one entry per cycle, as set by the single write and single registered read port.
// Reset clears the length and the sequencer; the store is not cleared, and no entry at
// or above the length is ever read. A new word is taken once the sequencer is idle,
// even while the previous result still waits under out_stall_i.
module indexed_list_table #(
  parameter int unsigned DEPTH = 64
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [ilt_pkg::REQ_W-1:0]      req_type_i,
  input  logic [ilt_pkg::POS_W-1:0]      position_in_i,
  input  logic [ilt_pkg::WORD_W-1:0]     element_value_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [ilt_pkg::STATUS_W-1:0]   status_o,
  output logic [ilt_pkg::WORD_W-1:0]     read_value_o,
  output logic                           found_o,
  output logic [ilt_pkg::FPOS_W-1:0]     found_position_o,
  output logic [ilt_pkg::LEN_W-1:0]      list_length_out_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned LW = $clog2(DEPTH + 1);

  logic                       we;
  logic [AW-1:0]              waddr;
  logic [ilt_pkg::WORD_W-1:0] wdata;
  logic                       re;
  logic [AW-1:0]              raddr;
  logic [ilt_pkg::WORD_W-1:0] rdata;
  logic                       res_valid;
  logic                       res_ready;
  ilt_pkg::res_t              res;
  ilt_pkg::res_t              out_q;
  logic                       out_valid_q;

  ilt_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  ilt_seq #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .LW    (LW)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .req_i       (req_type_i),
    .pos_i       (position_in_i),
    .val_i       (element_value_i),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .we_o        (we),
    .waddr_o     (waddr),
    .wdata_o     (wdata),
    .re_o        (re),
    .raddr_o     (raddr),
    .rdata_i     (rdata)
  );

  // The output register frees the sequencer as soon as a result is handed over.
  assign res_ready = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign status_o          = out_q.status;
  assign read_value_o      = out_q.read_value;
  assign found_o           = out_q.found;
  assign found_position_o  = out_q.found_position;
  assign list_length_out_o = out_q.list_length;

endmodule

>>> tb/testbench.sv
`timescale 1ns / 100ps

module testbench;

  localparam int unsigned DEPTH = 64;
  localparam int CLK_PERIOD = 10;
  localparam int QUIET_LIMIT = 5000;
  localparam int LONG_HOLD = 400;
  localparam logic [ilt_pkg::REQ_W-1:0] REQ_UNUSED_MAX = 4'd15;

  typedef struct {
    logic [ilt_pkg::REQ_W-1:0]  op;
    logic [ilt_pkg::POS_W-1:0]  pos;
    logic [ilt_pkg::WORD_W-1:0] val;
  } list_request_t;

  logic                         clk_i = 1'b0;
  logic                         rst_ni;
  logic                         in_valid_i = 1'b0;
  logic                         in_stall_o;
  logic [ilt_pkg::REQ_W-1:0]    req_type_i = '0;
  logic [ilt_pkg::POS_W-1:0]    position_in_i = '0;
  logic [ilt_pkg::WORD_W-1:0]   element_value_i = '0;
  logic                         out_valid_o;
  logic                         out_stall_i = 1'b0;
  logic [ilt_pkg::STATUS_W-1:0] status_o;
  logic [ilt_pkg::WORD_W-1:0]   read_value_o;
  logic                         found_o;
  logic [ilt_pkg::FPOS_W-1:0]   found_position_o;
  logic [ilt_pkg::LEN_W-1:0]    list_length_out_o;

  // Predicted contents of the list.
  logic [ilt_pkg::WORD_W-1:0] list_mem [DEPTH];
  int list_len = 0;

  list_request_t pending_requests[$];
  ilt_pkg::res_t expected_results[$];

  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_reqs = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int mismatches = 0;
  int quiet_cycles = 0;

  indexed_list_table #(
    .DEPTH(DEPTH)
  ) dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .req_type_i       (req_type_i),
    .position_in_i    (position_in_i),
    .element_value_i  (element_value_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .status_o         (status_o),
    .read_value_o     (read_value_o),
    .found_o          (found_o),
    .found_position_o (found_position_o),
    .list_length_out_o(list_length_out_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Applies one request to the predicted list and returns the result it gives.
  function automatic ilt_pkg::res_t apply_list_op(input logic [ilt_pkg::REQ_W-1:0] op,
                                                  input logic [ilt_pkg::POS_W-1:0] pos,
                                                  input logic [ilt_pkg::WORD_W-1:0] val);
    ilt_pkg::res_t r;
    int i;
    r = '0;
    case (op)
      ilt_pkg::REQ_APPEND: begin
        if (val == '0) r.status = ilt_pkg::ST_NULL;
        else if (list_len >= DEPTH) r.status = ilt_pkg::ST_FULL;
        else begin
          list_mem[list_len] = val;
          list_len++;
        end
      end
      ilt_pkg::REQ_INSERT: begin
        if (val == '0) r.status = ilt_pkg::ST_NULL;
        else if (pos > list_len) r.status = ilt_pkg::ST_BAD_POS;
        else if (list_len >= DEPTH) r.status = ilt_pkg::ST_FULL;
        else begin
          for (i = list_len; i > pos; i--) list_mem[i] = list_mem[i - 1];
          list_mem[pos] = val;
          list_len++;
        end
      end
      ilt_pkg::REQ_OVERWRITE: begin
        if (val == '0) r.status = ilt_pkg::ST_NULL;
        else if (pos >= list_len) r.status = ilt_pkg::ST_BAD_POS;
        else list_mem[pos] = val;
      end
      ilt_pkg::REQ_GET: begin
        if (pos >= list_len) r.status = ilt_pkg::ST_BAD_POS;
        else r.read_value = list_mem[pos];
      end
      ilt_pkg::REQ_REMOVE, ilt_pkg::REQ_POP: begin
        if (pos >= list_len) r.status = ilt_pkg::ST_BAD_POS;
        else begin
          if (op == ilt_pkg::REQ_POP) r.read_value = list_mem[pos];
          for (i = pos; i + 1 < list_len; i++) list_mem[i] = list_mem[i + 1];
          list_len--;
        end
      end
      ilt_pkg::REQ_SEARCH, ilt_pkg::REQ_CONTAINS: begin
        if (val == '0) r.status = ilt_pkg::ST_NULL;
        else begin
          r.status = ilt_pkg::ST_NOT_FOUND;
          for (i = 0; i < list_len; i++) begin
            if (list_mem[i] == val) begin
              r.status = ilt_pkg::ST_OK;
              r.found = 1'b1;
              r.found_position = i[ilt_pkg::FPOS_W-1:0];
              break;
            end
          end
        end
      end
      ilt_pkg::REQ_CLEAR: begin
        if (list_len == 0) r.status = ilt_pkg::ST_EMPTY;
        else list_len = 0;
      end
      default: ;
    endcase
    r.list_length = list_len[ilt_pkg::LEN_W-1:0];
    return r;
  endfunction

  // Random request, mostly aimed at positions in the list, often with a value it holds.
  function automatic list_request_t make_request(input int grow_pct);
    list_request_t it;
    int roll;
    int len;
    len = list_len;
    if ($urandom_range(0, 99) < grow_pct) begin
      it.op = $urandom_range(0, 1) ? ilt_pkg::REQ_APPEND : ilt_pkg::REQ_INSERT;
    end else begin
      roll = $urandom_range(0, 99);
      if (roll < 2) it.op = ilt_pkg::REQ_CLEAR;
      else if (roll < 5)
        it.op = ilt_pkg::REQ_W'($urandom_range(ilt_pkg::REQ_CLEAR + 1, REQ_UNUSED_MAX));
      else
        it.op = ilt_pkg::REQ_W'($urandom_range(ilt_pkg::REQ_OVERWRITE,
                                               ilt_pkg::REQ_CONTAINS));
    end
    roll = $urandom_range(0, 99);
    if (roll < 8) it.pos = ilt_pkg::POS_W'($urandom_range(0, (1 << ilt_pkg::POS_W) - 1));
    else if (roll < 16) it.pos = ilt_pkg::POS_W'(len);
    else it.pos = ilt_pkg::POS_W'($urandom_range(0, (len > 0) ? len - 1 : 0));
    roll = $urandom_range(0, 99);
    if (roll < 3) it.val = '0;
    else if (roll < 40 && len > 0) it.val = list_mem[$urandom_range(0, len - 1)];
    else if (roll < 70) it.val = $urandom_range(1, 12);
    else it.val = $urandom;
    return it;
  endfunction

  task automatic queue_request(input logic [ilt_pkg::REQ_W-1:0] op, input int pos,
                               input logic [ilt_pkg::WORD_W-1:0] val);
    list_request_t it;
    it.op = op;
    it.pos = ilt_pkg::POS_W'(pos);
    it.val = val;
    pending_requests.push_back(it);
  endtask

  task automatic wait_drained();
    while (pending_requests.size() != 0 || in_valid_i || expected_results.size() != 0)
      @(negedge clk_i);
  endtask

  task automatic run_phase(input int n, input int idle, input int stall, input int grow,
                           input bit long_hold);
    int k;
    @(negedge clk_i);
    send_idle_pct = idle;
    stall_pct = stall;
    if (long_hold) hold_reqs++;
    // Only a couple of words are queued ahead so positions track the list length.
    for (k = 0; k < n; k++) begin
      while (pending_requests.size() >= 2) @(negedge clk_i);
      pending_requests.push_back(make_request(grow));
    end
    wait_drained();
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : drive_requests
    list_request_t next_req;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o)
        expected_results.push_back(apply_list_op(req_type_i, position_in_i, element_value_i));
      if (!in_valid_i || !in_stall_o) begin
        if (pending_requests.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          next_req = pending_requests.pop_front();
          in_valid_i <= 1'b1;
          req_type_i <= next_req.op;
          position_in_i <= next_req.pos;
          element_value_i <= next_req.val;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin : check_results
    ilt_pkg::res_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          $error("result word with no request outstanding");
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          if (status_o !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status_o);
            mismatches++;
          end
          if (read_value_o !== want.read_value) begin
            $error("read_value: expected %h, got %h", want.read_value, read_value_o);
            mismatches++;
          end
          if (found_o !== want.found) begin
            $error("found: expected %0d, got %0d", want.found, found_o);
            mismatches++;
          end
          if (found_position_o !== want.found_position) begin
            $error("found_position: expected %0d, got %0d", want.found_position,
                   found_position_o);
            mismatches++;
          end
          if (list_length_out_o !== want.list_length) begin
            $error("list_length_out: expected %0d, got %0d", want.list_length,
                   list_length_out_o);
            mismatches++;
          end
        end
      end
      if (hold_seen != hold_reqs) begin
        hold_seen = hold_reqs;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    rst_ni = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Empty-list corner cases first, then a short build-up and teardown.
    queue_request(ilt_pkg::REQ_CLEAR, 0, 32'h0000_0001);
    queue_request(ilt_pkg::REQ_REMOVE, 0, 32'h0000_0001);
    queue_request(ilt_pkg::REQ_POP, 0, 32'h0000_0001);
    queue_request(ilt_pkg::REQ_GET, 0, 32'h0000_0000);
    queue_request(ilt_pkg::REQ_APPEND, 0, 32'h0000_0000);
    queue_request(ilt_pkg::REQ_SEARCH, 0, 32'hFFFF_FFFF);
    queue_request(ilt_pkg::REQ_APPEND, 0, 32'hFFFF_FFFF);
    queue_request(ilt_pkg::REQ_APPEND, 127, 32'h0000_0001);
    queue_request(ilt_pkg::REQ_INSERT, 0, 32'h8000_0000);
    queue_request(ilt_pkg::REQ_INSERT, 3, 32'h5555_5555);
    queue_request(ilt_pkg::REQ_INSERT, 3, 32'hAAAA_AAAA);
    queue_request(ilt_pkg::REQ_INSERT, 6, 32'h0000_0002);
    queue_request(ilt_pkg::REQ_INSERT, 99, 32'h0000_0000);
    queue_request(ilt_pkg::REQ_OVERWRITE, 1, 32'h1234_5678);
    queue_request(ilt_pkg::REQ_OVERWRITE, 5, 32'h0000_0003);
    queue_request(ilt_pkg::REQ_OVERWRITE, 0, 32'h0000_0000);
    queue_request(ilt_pkg::REQ_GET, 4, 32'h0000_0000);
    queue_request(ilt_pkg::REQ_SEARCH, 0, 32'h0000_0001);
    queue_request(ilt_pkg::REQ_CONTAINS, 0, 32'hAAAA_AAAA);
    queue_request(ilt_pkg::REQ_CONTAINS, 0, 32'h0000_0007);
    queue_request(ilt_pkg::REQ_POP, 0, 32'h0000_0000);
    queue_request(ilt_pkg::REQ_REMOVE, 3, 32'h0000_0000);
    queue_request(ilt_pkg::REQ_GET, 64, 32'h0000_0000);
    queue_request(REQ_UNUSED_MAX, 127, 32'hFFFF_FFFF);
    queue_request(ilt_pkg::REQ_CLEAR, 0, 32'h0000_0000);
    wait_drained();

    run_phase(250, 0, 0, 70, 1'b0);
    run_phase(250, 80, 0, 45, 1'b0);
    run_phase(250, 0, 80, 55, 1'b0);
    run_phase(250, 35, 35, 35, 1'b0);
    // The receiver holds off while words keep coming, so the input backs up.
    run_phase(100, 0, 0, 60, 1'b1);
    run_phase(200, 0, 0, 80, 1'b0);
    run_phase(150, 35, 35, 20, 1'b0);

    wait_drained();
    repeat (DEPTH + 8) @(posedge clk_i);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
